### src/pip_pkg.sv
// ----------------------------------------------------------------------------
// pip_pkg: shared definitions for the point-in-polygon crossing test
// Sizes, codes, sequencer states and the control structs between modules.
// ----------------------------------------------------------------------------
`default_nettype none

package pip_pkg;

   localparam int MAX_VERTICES = 16;
   localparam int COORD_BITS   = 32;
   localparam int MIN_VERTICES = 3;
   localparam int COUNT_RESET  = 4;

   // fixed widths of the channel fields
   localparam int FIELD_W = 32;
   localparam int INDEX_W = 4;
   localparam int CSR_W   = 5;

   localparam int ADDR_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
   localparam int DIFF_W = COORD_BITS + 1;
   localparam int PROD_W = 2 * DIFF_W;
   localparam int WORD_W = 2 * COORD_BITS;

   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_TEST  = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_DRAIN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic vld;    // read data valid this cycle
      logic first;  // that data is the closing vertex, no edge yet
   } edge_ctl_type;

   typedef struct packed {
      logic busy;
      logic odd;    // even-odd crossing parity so far
   } edge_stat_type;

   function automatic logic signed [COORD_BITS-1:0] coord_of(
      input logic signed [FIELD_W-1:0] v);
      return COORD_BITS'(v);
   endfunction

endpackage

`default_nettype wire

### src/pip_req_if.sv
// ----------------------------------------------------------------------------
// pip_req_if: request channel
// Valid/ready channel carrying a vertex write or a point query.
// ----------------------------------------------------------------------------
`default_nettype none

interface pip_req_if;
   logic                                  valid;
   logic                                  ready;
   logic                                  mode;
   logic [pip_pkg::INDEX_W-1:0]           vertex_index;
   logic signed [pip_pkg::FIELD_W-1:0]    coord_x;
   logic signed [pip_pkg::FIELD_W-1:0]    coord_y;

   modport source (output valid, output mode, output vertex_index,
                   output coord_x, output coord_y, input ready);
   modport sink   (input valid, input mode, input vertex_index,
                   input coord_x, input coord_y, output ready);
endinterface

`default_nettype wire

### src/pip_rsp_if.sv
// ----------------------------------------------------------------------------
// pip_rsp_if: response channel
// Valid/ready channel carrying the inside flag of a query.
// ----------------------------------------------------------------------------
`default_nettype none

interface pip_rsp_if;
   logic valid;
   logic ready;
   logic inside_res;

   modport source (output valid, output inside_res, input ready);
   modport sink   (input valid, input inside_res, output ready);
endinterface

`default_nettype wire

### src/pip_ram.sv
// ----------------------------------------------------------------------------
// pip_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module pip_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                           clock,
   input  wire logic                           we,
   input  wire logic [$clog2(DEPTH)-1:0]       waddr,
   input  wire logic [WIDTH-1:0]               wdata,
   input  wire logic                           re,
   input  wire logic [$clog2(DEPTH)-1:0]       raddr,
   output      logic [WIDTH-1:0]               rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

`default_nettype wire

### src/pip_edge.sv
// ----------------------------------------------------------------------------
// pip_edge: edge crossing pipeline
// Takes one vertex per cycle, forms the edge with the previous one, checks
// the straddle, cross-multiplies and toggles the even-odd flag.
// ----------------------------------------------------------------------------
`default_nettype none

module pip_edge (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire logic                                      clear,
   input  wire pip_pkg::edge_ctl_type                     ctl,
   input  wire logic signed [pip_pkg::COORD_BITS-1:0]     cur_x,
   input  wire logic signed [pip_pkg::COORD_BITS-1:0]     cur_y,
   input  wire logic signed [pip_pkg::COORD_BITS-1:0]     pt_x,
   input  wire logic signed [pip_pkg::COORD_BITS-1:0]     pt_y,
   output      pip_pkg::edge_stat_type                    stat
);

   localparam int DW = pip_pkg::DIFF_W;
   localparam int PW = pip_pkg::PROD_W;

   logic signed [pip_pkg::COORD_BITS-1:0] prev_x_ff, prev_y_ff;

   // stage A: differences
   logic                 a_vld_ff, a_vld_in;
   logic signed [DW-1:0] a_dx_ff, a_dx_in;     // px - xi
   logic signed [DW-1:0] a_dy_ff, a_dy_in;     // yj - yi
   logic signed [DW-1:0] a_ex_ff, a_ex_in;     // xj - xi
   logic signed [DW-1:0] a_ey_ff, a_ey_in;     // py - yi
   logic                 straddle;

   // stage B: products
   logic                 b_vld_ff;
   logic                 b_neg_ff;
   logic signed [PW-1:0] b_lhs_ff, b_lhs_in;
   logic signed [PW-1:0] b_rhs_ff, b_rhs_in;

   logic inside_ff, inside_in;
   logic hit;

   always_comb begin
      straddle = (cur_y >= pt_y) != (prev_y_ff >= pt_y);
      a_vld_in = ctl.vld && !ctl.first && straddle;
      a_dx_in  = DW'(pt_x) - DW'(cur_x);
      a_dy_in  = DW'(prev_y_ff) - DW'(cur_y);
      a_ex_in  = DW'(prev_x_ff) - DW'(cur_x);
      a_ey_in  = DW'(pt_y) - DW'(cur_y);
   end

   assign b_lhs_in = PW'(a_dx_ff) * PW'(a_dy_ff);
   assign b_rhs_in = PW'(a_ex_ff) * PW'(a_ey_ff);

   // dy is never zero on a straddling edge, so its sign picks the sense
   assign hit = b_neg_ff ? (b_lhs_ff >= b_rhs_ff) : (b_lhs_ff <= b_rhs_ff);

   always_comb begin
      inside_in = inside_ff;
      if (clear) begin
         inside_in = 1'b0;
      end else if (b_vld_ff && hit) begin
         inside_in = !inside_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff  <= 1'b0;
         b_vld_ff  <= 1'b0;
         inside_ff <= 1'b0;
      end else begin
         a_vld_ff  <= a_vld_in;
         b_vld_ff  <= a_vld_ff;
         inside_ff <= inside_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.vld) begin
         prev_x_ff <= cur_x;
         prev_y_ff <= cur_y;
      end
      a_dx_ff  <= a_dx_in;
      a_dy_ff  <= a_dy_in;
      a_ex_ff  <= a_ex_in;
      a_ey_ff  <= a_ey_in;
      b_neg_ff <= a_dy_ff[DW-1];
      b_lhs_ff <= b_lhs_in;
      b_rhs_ff <= b_rhs_in;
   end

   assign stat.busy = a_vld_ff || b_vld_ff;
   assign stat.odd  = inside_ff;

endmodule

`default_nettype wire

### src/point_in_polygon_test.sv
// ----------------------------------------------------------------------------
// point_in_polygon_test: even-odd point-in-polygon test
// Vertex store in RAM, a sequencer that walks the edges, and a registered
// response stage.
// ----------------------------------------------------------------------------
// Vertex write: no response.
// Query with n >= 3 vertices: n+1 vertex store reads, one per cycle, then the
// edge pipe drains and the response is registered. No new request is taken
// until that response has been registered and the sequencer is idle again.
// Query with n < 3: no store reads; the response is registered directly.
// Reset: vertex_count = 4, control cleared; store undefined until written.
`default_nettype none

module point_in_polygon_test (
   input  wire logic                         clock,
   input  wire logic                         reset,
   pip_req_if.sink                           req_chan,
   pip_rsp_if.source                         rsp_chan,
   input  wire logic                         csr_we,
   input  wire logic [pip_pkg::CSR_W-1:0]    csr_wdata
);

   localparam int AW = pip_pkg::ADDR_W;
   localparam int CW = pip_pkg::CNT_W;
   localparam int XB = pip_pkg::COORD_BITS;

   pip_pkg::state_type state_ff, state_in;

   logic [pip_pkg::CSR_W-1:0] vcount_ff;
   logic [CW-1:0]             cnt_ff, cnt_in, n_sat;
   logic [CW-1:0]             rd_ff, rd_in;
   logic                      short_ff, short_in;
   logic signed [XB-1:0]      px_ff, py_ff;
   logic                      rv_ff, first_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_inside_ff, rsp_inside_in;

   logic                      accept, start, clear, re;
   logic [AW-1:0]             raddr;
   logic                      we;
   logic [AW-1:0]             waddr;
   logic [pip_pkg::WORD_W-1:0] wdata, rdata;

   pip_pkg::edge_ctl_type     ectl;
   pip_pkg::edge_stat_type    estat;

   assign accept = req_chan.valid && req_chan.ready;
   assign start  = accept && (req_chan.mode == pip_pkg::MODE_TEST);

   assign n_sat = (32'(vcount_ff) > pip_pkg::MAX_VERTICES) ?
                  CW'(pip_pkg::MAX_VERTICES) : CW'(vcount_ff);

   // vertex write
   assign we    = accept && (req_chan.mode == pip_pkg::MODE_WRITE) &&
                  (32'(req_chan.vertex_index) < pip_pkg::MAX_VERTICES);
   assign waddr = AW'(req_chan.vertex_index);
   assign wdata = {pip_pkg::coord_of(req_chan.coord_x),
                   pip_pkg::coord_of(req_chan.coord_y)};

   // read the closing vertex first, then vertex 0 .. n-1
   assign raddr = (rd_ff == '0) ? AW'(cnt_ff - CW'(1)) : AW'(rd_ff - CW'(1));

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      short_in      = short_ff;
      rd_in         = rd_ff;
      re            = 1'b0;
      clear         = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_inside_in = rsp_inside_ff;
      unique case (state_ff)
         pip_pkg::ST_IDLE: begin
            if (start) begin
               cnt_in   = n_sat;
               short_in = 32'(n_sat) < pip_pkg::MIN_VERTICES;
               rd_in    = '0;
               clear    = 1'b1;
               state_in = (32'(n_sat) < pip_pkg::MIN_VERTICES) ?
                          pip_pkg::ST_DONE : pip_pkg::ST_READ;
            end
         end
         pip_pkg::ST_READ: begin
            re    = 1'b1;
            rd_in = rd_ff + CW'(1);
            if (rd_ff == cnt_ff) begin
               state_in = pip_pkg::ST_DRAIN;
            end
         end
         pip_pkg::ST_DRAIN: begin
            if (!rv_ff && !estat.busy) begin
               state_in = pip_pkg::ST_DONE;
            end
         end
         pip_pkg::ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_inside_in = short_ff ? 1'b0 : estat.odd;
               state_in      = pip_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pip_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pip_pkg::ST_IDLE;
         vcount_ff    <= pip_pkg::CSR_W'(pip_pkg::COUNT_RESET);
         cnt_ff       <= '0;
         short_ff     <= 1'b0;
         rd_ff        <= '0;
         rv_ff        <= 1'b0;
         first_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         if (csr_we) begin
            vcount_ff <= csr_wdata;
         end
         cnt_ff       <= cnt_in;
         short_ff     <= short_in;
         rd_ff        <= rd_in;
         rv_ff        <= re;
         first_ff     <= re && (rd_ff == '0);
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         px_ff <= pip_pkg::coord_of(req_chan.coord_x);
         py_ff <= pip_pkg::coord_of(req_chan.coord_y);
      end
      rsp_inside_ff <= rsp_inside_in;
   end

   pip_ram #(
      .WIDTH (pip_pkg::WORD_W),
      .DEPTH (pip_pkg::MAX_VERTICES)
   ) u_store (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .re    (re),
      .raddr (raddr),
      .rdata (rdata)
   );

   assign ectl.vld   = rv_ff;
   assign ectl.first = first_ff;

   pip_edge u_edge (
      .clock  (clock),
      .reset  (reset),
      .clear  (clear),
      .ctl    (ectl),
      .cur_x  (rdata[pip_pkg::WORD_W-1:XB]),
      .cur_y  (rdata[XB-1:0]),
      .pt_x   (px_ff),
      .pt_y   (py_ff),
      .stat   (estat)
   );

   assign req_chan.ready      = (state_ff == pip_pkg::ST_IDLE);
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.inside_res = rsp_inside_ff;

   a_walk_starts: assert property (@(posedge clock) disable iff (reset)
      start && (32'(n_sat) >= pip_pkg::MIN_VERTICES) |=> state_ff == pip_pkg::ST_READ)
      else $error("query with enough vertices did not start the edge walk");

   a_read_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == pip_pkg::ST_READ |-> rd_ff <= cnt_ff)
      else $error("read counter ran past the vertex count");

   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      state_ff == pip_pkg::ST_IDLE |-> !rv_ff && !estat.busy)
      else $error("edge pipe still active while idle");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      state_ff == pip_pkg::ST_DONE && rsp_valid_ff && !rsp_chan.ready
      |=> state_ff == pip_pkg::ST_DONE && rsp_valid_ff)
      else $error("result overwrote a pending response");

endmodule

`default_nettype wire

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: point-in-polygon crossing test
// Loads polygons into the vertex store, fires point queries at them under
// several vertex counts and handshake idle patterns, and compares each
// inside flag with an exact even-odd crossing predictor kept in step with
// every accepted beat.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import pip_pkg::*;

   typedef logic signed [FIELD_W-1:0]    field_type;
   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [DIFF_W-1:0]     diff_type;
   typedef logic signed [PROD_W-1:0]     prod_type;

   localparam field_type COORD_MIN = 32'sh8000_0000;
   localparam field_type COORD_MAX = 32'sh7fff_ffff;
   localparam field_type SIDE      = 32'sd10 <<< 16;   // 10.0 in Q16.16
   localparam int     N_PHASES  = 8;
   localparam int     PHASE_ITEMS = 55;

   // per random phase: vertex count, sender idle %, receiver stall %, scale
   localparam int PHASE_COUNT [N_PHASES] = '{3, 16, 5, 31, 8, 0, 12, 16};
   localparam int PHASE_IDLE  [N_PHASES] = '{0, 66, 0, 9, 0, 66, 0, 9};
   localparam int PHASE_STALL [N_PHASES] = '{0, 0, 66, 9, 0, 0, 66, 9};
   localparam int PHASE_SHIFT [N_PHASES] = '{0, 16, 8, 23, 16, 0, 4, 16};

   // ------------------------------------------------------------------------
   // Vertex store mirror, even-odd predictor and pending inside flags
   // ------------------------------------------------------------------------
   class polygon_scoreboard;
      coord_type        vert_x [MAX_VERTICES];
      coord_type        vert_y [MAX_VERTICES];
      logic [CSR_W-1:0] vertex_count;
      bit               expected_inside [$];
      int               mismatches;
      int               writes_seen;
      int               queries_seen;
      int               inside_seen;
      int               settings_seen;

      function new();
         vertex_count = CSR_W'(COUNT_RESET);
      endfunction

      function void set_count(logic [CSR_W-1:0] v);
         vertex_count = v;
         settings_seen++;
      endfunction

      function void note_mismatch(string what, int want, int got);
         mismatches++;
         if (mismatches <= 10)
            $display("[%0t] %s: expected %0d, got %0d", $realtime, what, want, got);
      endfunction

      // exact crossing compare, sense follows the sign of the edge's y span
      function bit crossing_parity(coord_type px, coord_type py);
         int       n;
         int       j;
         diff_type dy;
         diff_type dx_pt;
         diff_type dx_edge;
         diff_type dy_pt;
         prod_type lhs;
         prod_type rhs;
         bit       odd;
         n = (vertex_count > MAX_VERTICES) ? MAX_VERTICES : int'(vertex_count);
         odd = 1'b0;
         if (n < MIN_VERTICES)
            return 1'b0;
         j = n - 1;
         for (int i = 0; i < n; i++) begin
            if ((vert_y[i] >= py) != (vert_y[j] >= py)) begin
               dy      = vert_y[j] - vert_y[i];
               dx_pt   = px - vert_x[i];
               dx_edge = vert_x[j] - vert_x[i];
               dy_pt   = py - vert_y[i];
               lhs     = dx_pt * dy;
               rhs     = dx_edge * dy_pt;
               if ((dy > 0) ? (lhs <= rhs) : (lhs >= rhs))
                  odd = !odd;
            end
            j = i;
         end
         return odd;
      endfunction

      function void note_request(logic mode, logic [INDEX_W-1:0] idx,
                                 field_type x, field_type y);
         bit flag;
         if (mode == MODE_WRITE) begin
            if (idx < MAX_VERTICES) begin
               vert_x[idx] = x;
               vert_y[idx] = y;
            end
            writes_seen++;
         end else begin
            flag = crossing_parity(x, y);
            expected_inside = {expected_inside, flag};
            queries_seen++;
            if (flag)
               inside_seen++;
         end
      endfunction

      function void check_response(logic got);
         bit want;
         if (expected_inside.size() == 0) begin
            note_mismatch("response with no query pending", -1, got);
         end else begin
            want = expected_inside.pop_front();
            if (got !== want)
               note_mismatch("inside_res mismatch", want, got);
         end
      endfunction
   endclass

   // ------------------------------------------------------------------------
   // Clock, reset, DUT
   // ------------------------------------------------------------------------
   logic             clock = 1'b0;
   logic             reset;
   logic             csr_we;
   logic [CSR_W-1:0] csr_wdata;
   int               send_idle_pct  = 0;
   int               recv_stall_pct = 0;
   int               phase_shift    = 16;
   polygon_scoreboard polygon_board;

   always #5ns clock = ~clock;

   pip_req_if req_chan ();
   pip_rsp_if rsp_chan ();

   point_in_polygon_test u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // response side: random backpressure, check every accepted beat
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         polygon_board.check_response(rsp_chan.inside_res);
      rsp_chan.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
   end

   initial begin
      #5ms;
      $display("testbench failed");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------------
   task automatic send_beat(logic mode, logic [INDEX_W-1:0] idx, field_type x,
                            field_type y);
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.mode         <= mode;
      req_chan.vertex_index <= idx;
      req_chan.coord_x      <= x;
      req_chan.coord_y      <= y;
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);
      polygon_board.note_request(mode, idx, x, y);
   endtask

   task automatic write_vertex(int idx, field_type x, field_type y);
      send_beat(MODE_WRITE, INDEX_W'(idx), x, y);
   endtask

   task automatic query_point(field_type x, field_type y);
      // index is a don't-care on queries, toggle it anyway
      send_beat(MODE_TEST, INDEX_W'($urandom_range(MAX_VERTICES - 1, 0)), x, y);
   endtask

   // drop valid and wait for every pending flag, then let the pipe empty
   task automatic drain();
      req_chan.valid <= 1'b0;
      while (polygon_board.expected_inside.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_vertex_count(int v);
      drain();
      csr_we    <= 1'b1;
      csr_wdata <= CSR_W'(v);
      @(posedge clock);
      polygon_board.set_count(CSR_W'(v));
      csr_we    <= 1'b0;
   endtask

   // mostly small values at the phase scale, some stored vertex coordinates, extremes and full-range
   function automatic field_type pick_coord(bit is_y, bit from_store, int wild_pct);
      int sel;
      int s;
      int v;
      sel = $urandom_range(99, 0);
      if (from_store && sel < 15)
         return is_y ? polygon_board.vert_y[$urandom_range(MAX_VERTICES - 1, 0)]
                     : polygon_board.vert_x[$urandom_range(MAX_VERTICES - 1, 0)];
      sel = $urandom_range(99, 0);
      if (sel < wild_pct / 4)
         return COORD_MIN;
      if (sel < wild_pct / 2)
         return COORD_MAX;
      if (sel < wild_pct)
         return field_type'($urandom);
      s = int'($urandom_range(200, 0)) - 100;
      v = s <<< phase_shift;
      if ($urandom_range(1, 0))
         v += int'($urandom_range((1 << phase_shift) - 1, 0));
      return field_type'(v);
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   initial begin
      int n;
      polygon_board = new();
      reset                 <= 1'b1;
      csr_we                <= 1'b0;
      csr_wdata             <= '0;
      req_chan.valid        <= 1'b0;
      req_chan.mode         <= MODE_WRITE;
      req_chan.vertex_index <= '0;
      req_chan.coord_x      <= '0;
      req_chan.coord_y      <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // fill every slot so no query ever reads an unwritten entry;
      // slots 0..3 form a 20x20 square around the origin
      write_vertex(0, -SIDE, -SIDE);
      write_vertex(1,  SIDE, -SIDE);
      write_vertex(2,  SIDE,  SIDE);
      write_vertex(3, -SIDE,  SIDE);
      write_vertex(4, COORD_MIN, COORD_MAX);
      write_vertex(5, COORD_MAX, COORD_MIN);
      for (int k = 6; k < MAX_VERTICES; k++)
         write_vertex(k, pick_coord(0, 0, 0), pick_coord(1, 0, 0));

      // reset count of four: inside, outside, both side edges, vertex rows, extremes
      query_point(0, 0);
      query_point(2 * SIDE, 0);
      query_point(-SIDE, 0);
      query_point(SIDE, 0);
      query_point(0, -SIDE);
      query_point(0, SIDE);
      query_point(COORD_MIN, COORD_MIN);
      query_point(COORD_MAX, COORD_MAX);

      // too few vertices, then a count past the store size
      set_vertex_count(0);
      query_point(0, 0);
      set_vertex_count(2);
      query_point(0, 0);
      set_vertex_count(31);
      query_point(0, 0);
      query_point(COORD_MIN, 0);

      for (int p = 0; p < N_PHASES; p++) begin
         send_idle_pct  = PHASE_IDLE[p];
         recv_stall_pct = PHASE_STALL[p];
         phase_shift    = PHASE_SHIFT[p];
         set_vertex_count(PHASE_COUNT[p]);
         n = (PHASE_COUNT[p] > MAX_VERTICES) ? MAX_VERTICES : PHASE_COUNT[p];
         for (int k = 0; k < n; k++)
            write_vertex(k, pick_coord(0, 0, 10), pick_coord(1, 0, 10));
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if ($urandom_range(99, 0) < 25)
               write_vertex($urandom_range(MAX_VERTICES - 1, 0),
                            pick_coord(0, 0, 10), pick_coord(1, 0, 10));
            else
               query_point(pick_coord(0, 1, 25), pick_coord(1, 1, 25));
         end
      end

      req_chan.valid <= 1'b0;
      while (polygon_board.expected_inside.size() != 0)
         @(posedge clock);
      repeat (30) @(posedge clock);

      $display("%0d vertex writes and %0d point queries over %0d vertex-count settings",
               polygon_board.writes_seen, polygon_board.queries_seen,
               polygon_board.settings_seen + 1);
      $display("%0d queries landed inside, %0d outside; %0d mismatches",
               polygon_board.inside_seen,
               polygon_board.queries_seen - polygon_board.inside_seen,
               polygon_board.mismatches);
      if (polygon_board.mismatches == 0 && polygon_board.expected_inside.size() == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

endmodule

`default_nettype wire

### filelist.f
src/pip_pkg.sv
src/pip_req_if.sv
src/pip_rsp_if.sv
src/pip_ram.sv
src/pip_edge.sv
src/point_in_polygon_test.sv
tb/sv/testbench.sv
